### rtl/twisted_toeplitz_prepare_modq_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the twisted Toeplitz prepare unit
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TWISTED_TOEPLITZ_PREPARE_MODQ_UNIT_MACROS_SVH
`define TWISTED_TOEPLITZ_PREPARE_MODQ_UNIT_MACROS_SVH

`ifndef SYNTH
// condition holds at every edge
`define TTPM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);
// antecedent implies consequent in the same cycle
`define TTPM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define TTPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TTPM_ASSERT(lbl, cond, msg)
`define TTPM_ASSERT_IMPL(lbl, ante, cons, msg)
`define TTPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/ttpm_pkg.sv
// ---------------------------------------------------------------------------
// ttpm_pkg
// Types, constants and modular reduction helpers for the twisted Toeplitz
// prepare unit (modulus 3457, centered residues).
// ---------------------------------------------------------------------------
package ttpm_pkg;

  localparam int Q        = 3457;
  localparam int HALF_Q   = 1728;
  localparam int NUM_DEG  = 4;

  // offsets (multiples of Q) that make each reduction operand non-negative
  localparam int OFS_COEF = 10 * Q;      // covers a 16-bit signed coefficient
  localparam int OFS_A    = 74 * Q;      // covers av * -147
  localparam int OFS_TW   = 16380 * Q;   // covers twist * av

  // reciprocal of Q for quotient estimates, operands below 2^27
  localparam int RECIP_SHIFT = 40;
  localparam logic [28:0] RECIP_M =
    29'(((64'd1 << RECIP_SHIFT) + 64'(Q) - 64'd1) / 64'(Q));

  localparam logic        [13:0] Q_W14    = 14'(Q);
  localparam logic signed [13:0] Q_S14    = 14'(Q);
  localparam logic signed [13:0] HALF_S14 = 14'(HALF_Q);
  localparam logic signed [8:0]  A_FACTOR = -9'sd147;

  localparam logic [3:0] LAST_BEAT = 4'd15;

  typedef logic signed [15:0] coef_t;
  typedef logic signed [11:0] res_t;

  typedef struct packed {
    logic [3:0]  blk;
    logic [3:0]  lane;
    coef_t [3:0] coef;
    coef_t       twist;
  } lane_in_t;

  typedef struct packed {
    logic [3:0] blk;
    logic [3:0] lane;
    res_t [3:0] a;
    res_t [3:0] la;
  } lane_vals_t;

  // quotient estimate floor(u/Q), exact or one too large
  function automatic logic [14:0] modq_quot(input logic [26:0] u);
    logic [55:0] p;
    p = 56'(u) * 56'(RECIP_M);
    return p[RECIP_SHIFT +: 15];
  endfunction

  // remainder from the estimate, one correction, then center on zero
  function automatic res_t modq_fold(input logic [26:0] u, input logic [14:0] q);
    logic        [13:0] qq;
    logic signed [13:0] r;
    logic signed [13:0] r1;
    logic signed [13:0] r2;
    qq = q[13:0] * Q_W14;
    r  = signed'(u[13:0] - qq);
    r1 = (r < 0) ? r + Q_S14 : r;
    r2 = (r1 > HALF_S14) ? r1 - Q_S14 : r1;
    return r2[11:0];
  endfunction

endpackage

### rtl/ttpm_calc.sv
// ---------------------------------------------------------------------------
// ttpm_calc
// Five-stage pipeline: centers the four coefficients, then forms the scaled
// values a[d] and the twisted values la[d], all reduced modulo Q.
// ---------------------------------------------------------------------------
module ttpm_calc
  import ttpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       up_vld,
  output logic       up_rdy,
  input  lane_in_t   up_item,
  output logic       dn_vld,
  input  logic       dn_rdy,
  output lane_vals_t dn_vals
);

  logic [5:1] vld_r;
  logic [5:1] stg_rdy;

  logic [3:0] blk_r  [1:5];
  logic [3:0] lane_r [1:5];
  coef_t      tw1_r;
  coef_t      tw2_r;

  logic [16:0]        u1_r  [NUM_DEG];
  logic [4:0]         q1_r  [NUM_DEG];
  res_t               av2_r [NUM_DEG];
  logic signed [19:0] pa3_r [NUM_DEG];
  logic signed [27:0] pt3_r [NUM_DEG];
  logic [18:0]        ua4_r [NUM_DEG];
  logic [7:0]         qa4_r [NUM_DEG];
  logic [26:0]        ut4_r [NUM_DEG];
  logic [14:0]        qt4_r [NUM_DEG];
  res_t               a5_r  [NUM_DEG];
  res_t               la5_r [NUM_DEG];

  logic [16:0]        u1_nxt  [NUM_DEG];
  logic [14:0]        q1_nxt  [NUM_DEG];
  logic [18:0]        ua4_nxt [NUM_DEG];
  logic [26:0]        ut4_nxt [NUM_DEG];

  // stall chain: a stage takes new data when empty or when it moves on
  always_comb begin
    stg_rdy[5] = !vld_r[5] || dn_rdy;
    for (int k = 4; k >= 1; k--) begin
      stg_rdy[k] = !vld_r[k] || stg_rdy[k+1];
    end
  end

  assign up_rdy = stg_rdy[1];
  assign dn_vld = vld_r[5];

  // offset operands so every reduction works on a non-negative value
  always_comb begin
    logic signed [17:0] tc;
    logic signed [20:0] ta;
    logic signed [28:0] tt;
    for (int d = 0; d < NUM_DEG; d++) begin
      tc         = 18'(up_item.coef[d]) + 18'(OFS_COEF);
      u1_nxt[d]  = tc[16:0];
      q1_nxt[d]  = modq_quot(27'(u1_nxt[d]));
      ta         = 21'(pa3_r[d]) + 21'(OFS_A);
      ua4_nxt[d] = ta[18:0];
      tt         = 29'(pt3_r[d]) + 29'(OFS_TW);
      ut4_nxt[d] = tt[26:0];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stg_rdy[1]) vld_r[1] <= up_vld;
      for (int k = 2; k <= 5; k++) begin
        if (stg_rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    logic [14:0] qa_full;
    if (stg_rdy[1]) begin
      blk_r[1]  <= up_item.blk;
      lane_r[1] <= up_item.lane;
      tw1_r     <= up_item.twist;
      for (int d = 0; d < NUM_DEG; d++) begin
        u1_r[d] <= u1_nxt[d];
        q1_r[d] <= q1_nxt[d][4:0];
      end
    end
    if (stg_rdy[2]) begin
      blk_r[2]  <= blk_r[1];
      lane_r[2] <= lane_r[1];
      tw2_r     <= tw1_r;
      for (int d = 0; d < NUM_DEG; d++) begin
        av2_r[d] <= modq_fold(27'(u1_r[d]), 15'(q1_r[d]));
      end
    end
    if (stg_rdy[3]) begin
      blk_r[3]  <= blk_r[2];
      lane_r[3] <= lane_r[2];
      for (int d = 0; d < NUM_DEG; d++) begin
        pa3_r[d] <= 20'(av2_r[d]) * 20'(A_FACTOR);
        pt3_r[d] <= 28'(tw2_r) * 28'(av2_r[d]);
      end
    end
    if (stg_rdy[4]) begin
      blk_r[4]  <= blk_r[3];
      lane_r[4] <= lane_r[3];
      for (int d = 0; d < NUM_DEG; d++) begin
        qa_full   = modq_quot(27'(ua4_nxt[d]));
        ua4_r[d] <= ua4_nxt[d];
        qa4_r[d] <= qa_full[7:0];
        ut4_r[d] <= ut4_nxt[d];
        qt4_r[d] <= modq_quot(ut4_nxt[d]);
      end
    end
    if (stg_rdy[5]) begin
      blk_r[5]  <= blk_r[4];
      lane_r[5] <= lane_r[4];
      for (int d = 0; d < NUM_DEG; d++) begin
        a5_r[d]  <= modq_fold(27'(ua4_r[d]), 15'(qa4_r[d]));
        la5_r[d] <= modq_fold(ut4_r[d], qt4_r[d]);
      end
    end
  end

  // hand the finished value set to the emitter
  always_comb begin
    dn_vals.blk  = blk_r[5];
    dn_vals.lane = lane_r[5];
    for (int d = 0; d < NUM_DEG; d++) begin
      dn_vals.a[d]  = a5_r[d];
      dn_vals.la[d] = la5_r[d];
    end
  end

endmodule

### rtl/ttpm_emit.sv
// ---------------------------------------------------------------------------
// ttpm_emit
// Holds one lane's value set and sends its sixteen matrix words, one per
// beat, through a registered output stage.
// ---------------------------------------------------------------------------
`include "twisted_toeplitz_prepare_modq_unit_macros.svh"

module ttpm_emit
  import ttpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_vld,
  output logic        up_rdy,
  input  lane_vals_t  up_vals,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [11:0] word, [23:12] word_addr
  output logic        out_tlast
);

  logic       out_vld_r;
  logic [3:0] cnt_r;
  logic       last_r;
  lane_vals_t bank_r;
  res_t       word_r;
  logic [11:0] addr_r;

  logic       load;
  logic       adv;
  logic       done;
  lane_vals_t src;
  logic [3:0] idx_nxt;
  logic [1:0] d_nxt;
  logic [1:0] c_nxt;
  logic [1:0] diff;
  res_t       word_nxt;
  logic [11:0] addr_nxt;

  // take a new value set once the last word of the current one leaves
  assign done   = out_vld_r && out_tready && last_r;
  assign up_rdy = !out_vld_r || (out_tready && last_r);
  assign load   = up_vld && up_rdy;
  assign adv    = out_vld_r && out_tready && !last_r;

  // select the word and address of the next beat
  always_comb begin
    src      = load ? up_vals : bank_r;
    idx_nxt  = load ? 4'd0 : cnt_r + 4'd1;
    d_nxt    = idx_nxt[3:2];
    c_nxt    = idx_nxt[1:0];
    diff     = d_nxt - c_nxt;
    word_nxt = (c_nxt <= d_nxt) ? src.a[diff] : src.la[diff];
    addr_nxt = {src.blk, d_nxt, src.lane[2], c_nxt[1], src.lane[3],
                src.lane[1:0], c_nxt[0]};
  end

  // beat control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      cnt_r     <= '0;
      last_r    <= 1'b0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
        cnt_r     <= '0;
        last_r    <= 1'b0;
      end else if (done) begin
        out_vld_r <= 1'b0;
      end else if (adv) begin
        cnt_r  <= idx_nxt;
        last_r <= (idx_nxt == LAST_BEAT);
      end
    end
  end

  // output payload and held value set
  always_ff @(posedge clk) begin
    if (load) bank_r <= up_vals;
    if (load || adv) begin
      word_r <= word_nxt;
      addr_r <= addr_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {addr_r, word_r};
  assign out_tlast  = last_r;

  `TTPM_ASSERT_NEXT(a_load_first, load, out_vld_r && cnt_r == 4'd0, "load must start at beat zero")
  `TTPM_ASSERT_NEXT(a_adv_step, adv, cnt_r == 4'($past(cnt_r) + 4'd1), "beat count must step by one")
  `TTPM_ASSERT_IMPL(a_last_match, out_vld_r, last_r == (cnt_r == LAST_BEAT), "last flag out of step")
  `TTPM_ASSERT_NEXT(a_done_idle, done && !load, !out_vld_r, "output must idle after last word")
  `TTPM_ASSERT_IMPL(a_word_range, out_vld_r, word_r >= -12'sd1728 && word_r <= 12'sd1728, "word outside centered range")

endmodule

### rtl/twisted_toeplitz_prepare_modq_unit.sv
// ---------------------------------------------------------------------------
// twisted_toeplitz_prepare_modq_unit
// Builds the packed Toeplitz matrix words of one lane modulo 3457.
// ---------------------------------------------------------------------------
// Each accepted item (one lane: four coefficients and a twist factor) yields
// sixteen centered words with their matrix addresses, in order of degree and
// column, the sixteenth marked by out_tlast. The single result channel sends
// one word per cycle while out_tready is high; the next item is taken while
// the current one drains, and its first word follows the previous last word
// directly. An item passes through the input register, the five arithmetic
// stages and the output register before its first word is on the output.
module twisted_toeplitz_prepare_modq_unit
  import ttpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [3:0] block_index, [7:4] lane, [23:8] coef_deg0, [39:24] coef_deg1,
  // [55:40] coef_deg2, [71:56] coef_deg3, [87:72] twist
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [11:0] word, [23:12] word_addr
  output logic [23:0] out_tdata,
  output logic        out_tlast
);

  logic       in_vld_r;
  lane_in_t   in_item_r;
  lane_in_t   in_item_nxt;
  logic       calc_rdy;
  logic       vals_vld;
  logic       vals_rdy;
  lane_vals_t vals;

  // unpack the input item
  always_comb begin
    in_item_nxt.blk     = in_tdata[3:0];
    in_item_nxt.lane    = in_tdata[7:4];
    in_item_nxt.coef[0] = in_tdata[23:8];
    in_item_nxt.coef[1] = in_tdata[39:24];
    in_item_nxt.coef[2] = in_tdata[55:40];
    in_item_nxt.coef[3] = in_tdata[71:56];
    in_item_nxt.twist   = in_tdata[87:72];
  end

  assign in_tready = !in_vld_r || calc_rdy;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_item_r <= in_item_nxt;
  end

  ttpm_calc u_calc (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_vld  (in_vld_r),
    .up_rdy  (calc_rdy),
    .up_item (in_item_r),
    .dn_vld  (vals_vld),
    .dn_rdy  (vals_rdy),
    .dn_vals (vals)
  );

  ttpm_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_vld     (vals_vld),
    .up_rdy     (vals_rdy),
    .up_vals    (vals),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
